/* hdl/qkag_pkg.sv */
package qkag_pkg;

	// Largest image side; coordinate and dimension widths follow from it.
	localparam int MAX_DIM       = 4096;
	localparam int COORD_W       = $clog2(MAX_DIM);
	localparam int DIM_W         = $clog2(MAX_DIM + 1);
	localparam int FRAC_BITS_DEF = 16;

	// Corner fields: x in the low half-word, y above it.
	localparam int CX_W   = 16;
	localparam int CY_W   = 12;
	localparam int CY_LSB = 16;

	localparam int CFG_W     = 28;
	localparam int CFG_IDX_W = 3;
	localparam int BPP_W     = 3;
	localparam int OFF_W     = 26;
	localparam int ROW_W     = COORD_W + DIM_W;

	localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] DST_WIDTH_RST  = DIM_W'(320);
	localparam logic [DIM_W-1:0] DST_HEIGHT_RST = DIM_W'(240);
	localparam logic [BPP_W-1:0] BPP_RST        = BPP_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORNER_TL = 3'd0,
		REG_CORNER_TR = 3'd1,
		REG_CORNER_BR = 3'd2,
		REG_CORNER_BL = 3'd3,
		REG_SRC_WIDTH = 3'd4,
		REG_DST_WIDTH = 3'd5,
		REG_DST_HEIGHT = 3'd6,
		REG_BPP       = 3'd7
	} cfg_reg_t;

	// Coordinate and range flag that travel alongside the pipeline.
	typedef struct packed {
		logic               err;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pix_t;

endpackage

/* hdl/qkag_frac_div.sv */
module qkag_frac_div #(
	parameter int FRAC_BITS = qkag_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  qkag_pkg::pix_t             in_pix,
	input  logic [qkag_pkg::DIM_W-1:0] den_x,
	input  logic [qkag_pkg::DIM_W-1:0] den_y,
	output logic                       out_vld,
	output qkag_pkg::pix_t             out_pix,
	output logic [FRAC_BITS-1:0]       u,
	output logic [FRAC_BITS-1:0]       v
);
	import qkag_pkg::*;

	// One restoring step per stage for both fractions.
	logic                 vld_s   [FRAC_BITS];
	pix_t                 pix_s   [FRAC_BITS];
	logic [DIM_W-1:0]     rem_x_s [FRAC_BITS];
	logic [DIM_W-1:0]     rem_y_s [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_x_s [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_y_s [FRAC_BITS];

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
		logic                 vld_prev;
		pix_t                 pix_prev;
		logic [DIM_W-1:0]     rx_prev;
		logic [DIM_W-1:0]     ry_prev;
		logic [FRAC_BITS-1:0] qx_prev;
		logic [FRAC_BITS-1:0] qy_prev;
		logic [DIM_W:0]       tx;
		logic [DIM_W:0]       ty;
		logic [DIM_W:0]       dx;
		logic [DIM_W:0]       dy;
		logic                 gex;
		logic                 gey;

		if (k == 0) begin : g_first
			// An out-of-range item starts from zero; its offsets are zeroed at the output.
			assign vld_prev = in_vld;
			assign pix_prev = in_pix;
			assign rx_prev  = in_pix.err ? '0 : {{(DIM_W-COORD_W){1'b0}}, in_pix.x};
			assign ry_prev  = in_pix.err ? '0 : {{(DIM_W-COORD_W){1'b0}}, in_pix.y};
			assign qx_prev  = '0;
			assign qy_prev  = '0;
		end else begin : g_next
			assign vld_prev = vld_s[k-1];
			assign pix_prev = pix_s[k-1];
			assign rx_prev  = rem_x_s[k-1];
			assign ry_prev  = rem_y_s[k-1];
			assign qx_prev  = quo_x_s[k-1];
			assign qy_prev  = quo_y_s[k-1];
		end

		always_comb begin
			tx  = {rx_prev, 1'b0};
			ty  = {ry_prev, 1'b0};
			dx  = tx - {1'b0, den_x};
			dy  = ty - {1'b0, den_y};
			gex = tx >= {1'b0, den_x};
			gey = ty >= {1'b0, den_y};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (vld_prev) begin
				pix_s[k]   <= pix_prev;
				rem_x_s[k] <= gex ? dx[DIM_W-1:0] : tx[DIM_W-1:0];
				rem_y_s[k] <= gey ? dy[DIM_W-1:0] : ty[DIM_W-1:0];
				quo_x_s[k] <= {qx_prev[FRAC_BITS-2:0], gex};
				quo_y_s[k] <= {qy_prev[FRAC_BITS-2:0], gey};
			end
		end
	end

	assign out_vld = vld_s[FRAC_BITS-1];
	assign out_pix = pix_s[FRAC_BITS-1];
	assign u       = quo_x_s[FRAC_BITS-1];
	assign v       = quo_y_s[FRAC_BITS-1];

endmodule

/* hdl/quad_keystone_address_gen_top.sv */
// Keystone warp address generator with nearest-source sampling.
//
// Command channel: present out_x/out_y with start high; the item is taken at
// any rising edge where start is high and busy is low. busy stays low, so a
// new coordinate may be issued every cycle.
// Result channel: done pulses for exactly one cycle with source_offset,
// dest_offset and coord_error. The receiver cannot hold results off, and
// none is needed: the pipeline never stalls, so every item comes out.
// The fraction divider takes one quotient bit per stage; throughput is one
// item per cycle.
// Configuration: cfg_wr_en with cfg_index/cfg_data writes one register at an
// edge; write only while no items are in flight.
// Reset: arst_n clears the corners, loads the default sizes and byte count,
// and flushes every item in flight without producing its result.
// A coordinate outside the output size returns coord_error with both
// offsets zero.
module quad_keystone_address_gen_top #(
	parameter int FRAC_BITS = qkag_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           start,
	output logic                           busy,
	input  logic [qkag_pkg::COORD_W-1:0]   out_x,
	input  logic [qkag_pkg::COORD_W-1:0]   out_y,
	// result channel
	output logic                           done,
	output logic [qkag_pkg::OFF_W-1:0]     source_offset,
	output logic [qkag_pkg::OFF_W-1:0]     dest_offset,
	output logic                           coord_error,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [qkag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qkag_pkg::CFG_W-1:0]     cfg_data
);
	import qkag_pkg::*;

	localparam int PX_W  = CX_W + FRAC_BITS + 2;  // edge blend product, x
	localparam int PY_W  = CY_W + FRAC_BITS + 2;
	localparam int TX_W  = CX_W + FRAC_BITS;      // edge blend value, x
	localparam int TY_W  = CY_W + FRAC_BITS;
	localparam int QX_W  = TX_W + FRAC_BITS + 2;  // second blend product, x
	localparam int QY_W  = TY_W + FRAC_BITS + 2;
	localparam int SRW_W = CY_W + DIM_W;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [CFG_W-1:0] corner_tl_q;
	logic [CFG_W-1:0] corner_tr_q;
	logic [CFG_W-1:0] corner_br_q;
	logic [CFG_W-1:0] corner_bl_q;
	logic [DIM_W-1:0] src_width_q;
	logic [DIM_W-1:0] dst_width_q;
	logic [DIM_W-1:0] dst_height_q;
	logic [BPP_W-1:0] bpp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_tl_q  <= '0;
			corner_tr_q  <= '0;
			corner_br_q  <= '0;
			corner_bl_q  <= '0;
			src_width_q  <= SRC_WIDTH_RST;
			dst_width_q  <= DST_WIDTH_RST;
			dst_height_q <= DST_HEIGHT_RST;
			bpp_q        <= BPP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CORNER_TL:  corner_tl_q  <= cfg_data;
				REG_CORNER_TR:  corner_tr_q  <= cfg_data;
				REG_CORNER_BR:  corner_br_q  <= cfg_data;
				REG_CORNER_BL:  corner_bl_q  <= cfg_data;
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[DIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DIM_W-1:0];
				REG_BPP:        bpp_q        <= cfg_data[BPP_W-1:0];
			endcase
		end
	end

	// Corner coordinates: x in the low half-word, y above it.
	logic [CX_W-1:0] tl_x, tr_x, br_x, bl_x;
	logic [CY_W-1:0] tl_y, tr_y, br_y, bl_y;

	assign tl_x = corner_tl_q[CX_W-1:0];
	assign tr_x = corner_tr_q[CX_W-1:0];
	assign br_x = corner_br_q[CX_W-1:0];
	assign bl_x = corner_bl_q[CX_W-1:0];
	assign tl_y = corner_tl_q[CY_LSB+CY_W-1:CY_LSB];
	assign tr_y = corner_tr_q[CY_LSB+CY_W-1:CY_LSB];
	assign br_y = corner_br_q[CY_LSB+CY_W-1:CY_LSB];
	assign bl_y = corner_bl_q[CY_LSB+CY_W-1:CY_LSB];

	// The pipeline always advances, so a transfer is taken in every cycle that start is high.
	assign busy = 1'b0;

	// ---------------------------------------------------------------------
	// Stage 1: capture the coordinate and flag it against the output size.
	// A zero width or height makes every coordinate out of range, so the
	// divider never sees a zero divisor on an item that matters.
	// ---------------------------------------------------------------------
	logic vld_s1;
	pix_t pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_s1.x   <= out_x;
			pix_s1.y   <= out_y;
			pix_s1.err <= ({1'b0, out_x} >= dst_width_q) || ({1'b0, out_y} >= dst_height_q);
		end
	end

	// ---------------------------------------------------------------------
	// Fraction divider: u = x*2^F / width, v = y*2^F / height, truncated.
	// ---------------------------------------------------------------------
	logic                 div_vld;
	pix_t                 div_pix;
	logic [FRAC_BITS-1:0] div_u;
	logic [FRAC_BITS-1:0] div_v;

	qkag_frac_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_frac_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_pix  (pix_s1),
		.den_x   (dst_width_q),
		.den_y   (dst_height_q),
		.out_vld (div_vld),
		.out_pix (div_pix),
		.u       (div_u),
		.v       (div_v)
	);

	// ---------------------------------------------------------------------
	// Stage 2: edge blend products. a*(one-w) + b*w is rewritten as
	// a*one + (b-a)*w, so each edge costs one signed multiply.
	// The destination row product runs alongside.
	// ---------------------------------------------------------------------
	logic signed [CX_W:0] dx_top, dx_bot;
	logic signed [CY_W:0] dy_left, dy_right;

	always_comb begin
		dx_top   = $signed({1'b0, tr_x}) - $signed({1'b0, tl_x});
		dx_bot   = $signed({1'b0, br_x}) - $signed({1'b0, bl_x});
		dy_left  = $signed({1'b0, bl_y}) - $signed({1'b0, tl_y});
		dy_right = $signed({1'b0, br_y}) - $signed({1'b0, tr_y});
	end

	logic                    vld_s2;
	pix_t                    pix_s2;
	logic [FRAC_BITS-1:0]    u_s2, v_s2;
	logic signed [PX_W-1:0]  prod_top_s2, prod_bot_s2;
	logic signed [PY_W-1:0]  prod_left_s2, prod_right_s2;
	logic [ROW_W-1:0]        dst_row_s2;

	always_ff @(posedge clk) begin
		if (div_vld) begin
			pix_s2        <= div_pix;
			u_s2          <= div_u;
			v_s2          <= div_v;
			prod_top_s2   <= dx_top * $signed({1'b0, div_u});
			prod_bot_s2   <= dx_bot * $signed({1'b0, div_u});
			prod_left_s2  <= dy_left * $signed({1'b0, div_v});
			prod_right_s2 <= dy_right * $signed({1'b0, div_v});
			dst_row_s2    <= div_pix.y * dst_width_q;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: finish the edge blends; each result is non-negative.
	// ---------------------------------------------------------------------
	logic signed [PX_W-1:0] top_full, bot_full;
	logic signed [PY_W-1:0] left_full, right_full;

	always_comb begin
		top_full   = $signed({2'b00, tl_x, {FRAC_BITS{1'b0}}}) + prod_top_s2;
		bot_full   = $signed({2'b00, bl_x, {FRAC_BITS{1'b0}}}) + prod_bot_s2;
		left_full  = $signed({2'b00, tl_y, {FRAC_BITS{1'b0}}}) + prod_left_s2;
		right_full = $signed({2'b00, tr_y, {FRAC_BITS{1'b0}}}) + prod_right_s2;
	end

	logic                 vld_s3;
	logic                 err_s3;
	logic [FRAC_BITS-1:0] u_s3, v_s3;
	logic [TX_W-1:0]      top_s3, bot_s3;
	logic [TY_W-1:0]      left_s3, right_s3;
	logic [OFF_W-1:0]     dst_sum_s3;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			err_s3     <= pix_s2.err;
			u_s3       <= u_s2;
			v_s3       <= v_s2;
			top_s3     <= top_full[TX_W-1:0];
			bot_s3     <= bot_full[TX_W-1:0];
			left_s3    <= left_full[TY_W-1:0];
			right_s3   <= right_full[TY_W-1:0];
			dst_sum_s3 <= {{(OFF_W-COORD_W){1'b0}}, pix_s2.x}
				+ {{(OFF_W-ROW_W){1'b0}}, dst_row_s2};
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: second blend products, across the other weight.
	// Scale the destination offset by the pixel size here.
	// ---------------------------------------------------------------------
	logic signed [TX_W:0]        dx_vert;
	logic signed [TY_W:0]        dy_horz;
	logic [OFF_W+BPP_W-1:0]      dst_scaled;

	always_comb begin
		dx_vert    = $signed({1'b0, bot_s3}) - $signed({1'b0, top_s3});
		dy_horz    = $signed({1'b0, right_s3}) - $signed({1'b0, left_s3});
		dst_scaled = dst_sum_s3 * bpp_q;
	end

	logic                   vld_s4;
	logic                   err_s4;
	logic [TX_W-1:0]        top_s4;
	logic [TY_W-1:0]        left_s4;
	logic signed [QX_W-1:0] prod_sx_s4;
	logic signed [QY_W-1:0] prod_sy_s4;
	logic [OFF_W-1:0]       dst_s4;

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			err_s4     <= err_s3;
			top_s4     <= top_s3;
			left_s4    <= left_s3;
			prod_sx_s4 <= dx_vert * $signed({1'b0, v_s3});
			prod_sy_s4 <= dy_horz * $signed({1'b0, u_s3});
			dst_s4     <= dst_scaled[OFF_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: finish the blend and truncate to a whole source pixel.
	// ---------------------------------------------------------------------
	logic signed [QX_W-1:0] sx_full;
	logic signed [QY_W-1:0] sy_full;

	always_comb begin
		sx_full = $signed({2'b00, top_s4, {FRAC_BITS{1'b0}}}) + prod_sx_s4;
		sy_full = $signed({2'b00, left_s4, {FRAC_BITS{1'b0}}}) + prod_sy_s4;
	end

	logic             vld_s5;
	logic             err_s5;
	logic [CX_W-1:0]  sx_s5;
	logic [CY_W-1:0]  sy_s5;
	logic [OFF_W-1:0] dst_s5;

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			err_s5 <= err_s4;
			sx_s5  <= sx_full[CX_W+2*FRAC_BITS-1:2*FRAC_BITS];
			sy_s5  <= sy_full[CY_W+2*FRAC_BITS-1:2*FRAC_BITS];
			dst_s5 <= dst_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 6: source row product.
	// ---------------------------------------------------------------------
	logic             vld_s6;
	logic             err_s6;
	logic [CX_W-1:0]  sx_s6;
	logic [SRW_W-1:0] src_row_s6;
	logic [OFF_W-1:0] dst_s6;

	always_ff @(posedge clk) begin
		if (vld_s5) begin
			err_s6     <= err_s5;
			sx_s6      <= sx_s5;
			src_row_s6 <= sy_s5 * src_width_q;
			dst_s6     <= dst_s5;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 7: source pixel index, wrapped to the offset width.
	// ---------------------------------------------------------------------
	logic             vld_s7;
	logic             err_s7;
	logic [OFF_W-1:0] src_sum_s7;
	logic [OFF_W-1:0] dst_s7;

	always_ff @(posedge clk) begin
		if (vld_s6) begin
			err_s7     <= err_s6;
			src_sum_s7 <= {{(OFF_W-CX_W){1'b0}}, sx_s6}
				+ {{(OFF_W-SRW_W){1'b0}}, src_row_s6};
			dst_s7     <= dst_s6;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 8: scale the source offset and drive the result; zero both
	// offsets for an out-of-range coordinate.
	// ---------------------------------------------------------------------
	logic [OFF_W+BPP_W-1:0] src_scaled;

	assign src_scaled = src_sum_s7 * bpp_q;

	logic             vld_s8;
	logic             err_s8;
	logic [OFF_W-1:0] src_off_s8;
	logic [OFF_W-1:0] dst_off_s8;

	always_ff @(posedge clk) begin
		if (vld_s7) begin
			err_s8     <= err_s7;
			src_off_s8 <= err_s7 ? '0 : src_scaled[OFF_W-1:0];
			dst_off_s8 <= err_s7 ? '0 : dst_s7;
		end
	end

	// Valid bits: advance one stage every cycle, clear on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s2 <= div_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	assign done          = vld_s8;
	assign coord_error   = err_s8;
	assign source_offset = src_off_s8;
	assign dest_offset   = dst_off_s8;

endmodule

/* hdl/qkag_checker.sv */
module qkag_checker #(
	parameter int FRAC_BITS = qkag_pkg::FRAC_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [qkag_pkg::OFF_W-1:0] source_offset,
	input logic [qkag_pkg::OFF_W-1:0] dest_offset,
	input logic                       coord_error
);
	import qkag_pkg::*;

	localparam int LAT   = FRAC_BITS + 8;
	localparam int AGE_W = $clog2(LAT + 1);

	// Edges since reset, held at the latency once enough have passed.
	logic [AGE_W-1:0] age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGE_W'(LAT)) begin
			age_q <= age_q + 1'b1;
		end
	end

	// Every result comes from a transfer exactly the latency earlier.
	a_done_has_cmd : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching command");

	// No command is lost once the pipeline has run clear of reset.
	a_cmd_gives_done : assert property (@(posedge clk) disable iff (!arst_n)
		(age_q == AGE_W'(LAT)) && $past(start && !busy, LAT) |-> done)
		else $error("command produced no result");

	// Out-of-range results carry zero offsets.
	a_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && coord_error |-> (source_offset == '0) && (dest_offset == '0))
		else $error("error result with non-zero offset");

	// The pipeline never holds a command off.
	a_busy_low : assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind quad_keystone_address_gen_top qkag_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_qkag_checker (.*);
